// ----- src/gpars_pkg.sv -----
package gpars_pkg;

  // Default sizes of the stored grid
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int OP_W      = 3;
  localparam int COORD_W   = 7;
  localparam int EXT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [EXT_W-1:0] EXT_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SET   = 3'd1,
    OP_GET   = 3'd2,
    OP_SUM   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_EXTENT = 2'd0,
    CFG_COL_EXTENT = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DELTA,
    ST_UPD,
    ST_UPD_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ----- src/grid_point_add_rect_sum_top.sv -----
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_ready  operation, row, col, row_end, col_end, value
// out_     output     out_valid/out_ready result, error
// cfg_     input      cfg_we (no wait)   cfg_index, cfg_wdata
//
// One transaction at a time through one shared adder, one memory read per cycle.
// Add: an upward tree walk, reading each node and writing it back (49 nodes at 64 x 64).
// Get and sum: four prefix walks, each stepping through its nodes and row steps to its
// walk end, then a drain. Set: get, then the delta, then add.
// Reset and clear: a zeroing sweep of MAX_ROWS * 2^clog2(MAX_COLS) words (4096 by
// default), no input taken; a result waiting on out_ready holds the block in done.
module grid_point_add_rect_sum_top #(
  parameter int MAX_ROWS    = gpars_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = gpars_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = gpars_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gpars_pkg::OP_W-1:0]          in_operation,
  input  logic [gpars_pkg::COORD_W-1:0]       in_row,
  input  logic [gpars_pkg::COORD_W-1:0]       in_col,
  input  logic [gpars_pkg::COORD_W-1:0]       in_row_end,
  input  logic [gpars_pkg::COORD_W-1:0]       in_col_end,
  input  logic signed [gpars_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gpars_pkg::DATA_W-1:0] out_result,
  output logic                                out_error,
  input  logic                                cfg_we,
  input  logic [gpars_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpars_pkg::EXT_W-1:0]         cfg_wdata
);
  import gpars_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS + 1);
  localparam int CIW   = $clog2(MAX_COLS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);
  localparam int IW    = (RIW > CIW) ? RIW : CIW;
  localparam int EW    = ((IW > COORD_W) ? IW : COORD_W) + 1;
  localparam int VW    = VALUE_WIDTH;
  localparam logic [1:0] WALK_LAST = 2'd3;

  // Control and payload registers
  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic               err_r, err_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [RIW-1:0]     r0_r, r0_nxt, r1_r, r1_nxt, i_r, i_nxt;
  logic [CIW-1:0]     c0_r, c0_nxt, c1_r, c1_nxt, j_r, j_nxt;
  logic [1:0]         walk_r, walk_nxt;
  logic [VW-1:0]      acc_r, acc_nxt, value_r, value_nxt;
  logic               rd_pend_r, rd_pend_nxt, rd_sub_r, rd_sub_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_result_r, out_result_nxt;
  logic               out_error_r, out_error_nxt;
  logic [EXT_W-1:0]   row_ext_r, col_ext_r;

  // Memory and shared adder
  logic [VW-1:0]      mem [DEPTH];
  logic [VW-1:0]      rd_q;
  logic               rd_en, mem_we;
  logic [AW-1:0]      rd_addr, mem_waddr;
  logic [VW-1:0]      mem_wdata;
  logic [VW-1:0]      add_a, add_b, add_y;
  logic               add_sub;

  // Decode helpers
  logic [EW-1:0]      row_e, col_e, re_e, ce_e, nr, nc;
  logic               cell_bad, rect_bad;
  logic [1:0]         walk_n;
  logic [RIW-1:0]     rs_n, i_lb;
  logic [CIW-1:0]     cs, cs_n, j_lb;
  logic [RIW:0]       i_up;
  logic [CIW:0]       j_up;
  logic [VW-1:0]      res_vw;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  // Effective extents and range checks
  always_comb begin
    row_e = EW'(in_row);
    col_e = EW'(in_col);
    re_e  = EW'(in_row_end);
    ce_e  = EW'(in_col_end);
    nr = (EW'(row_ext_r) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(row_ext_r);
    nc = (EW'(col_ext_r) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(col_ext_r);
    cell_bad = (row_e >= nr) || (col_e >= nc);
    rect_bad = (row_e > re_e) || (col_e > ce_e) || (re_e > nr) || (ce_e > nc);
  end

  // Walk index arithmetic
  always_comb begin
    walk_n = walk_r + 2'd1;
    cs     = walk_r[1] ? c0_r : c1_r;
    rs_n   = walk_n[0] ? r0_r : r1_r;
    cs_n   = walk_n[1] ? c0_r : c1_r;
    i_lb   = i_r & (~i_r + 1'b1);
    j_lb   = j_r & (~j_r + 1'b1);
    i_up   = {1'b0, i_r} + {1'b0, i_lb};
    j_up   = {1'b0, j_r} + {1'b0, j_lb};
  end

  // Memory port selection
  always_comb begin
    rd_addr   = {RW'(i_r - 1'b1), CW'(j_r - 1'b1)};
    rd_en     = ((state_r == ST_WALK) && (i_r != '0) && (j_r != '0)) ||
                (state_r == ST_UPD);
    mem_we    = (state_r == ST_CLEAR) || wr_pend_r;
    mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr_r;
    mem_wdata = (state_r == ST_CLEAR) ? '0 : add_y;
  end

  // Shared adder: accumulate, read-modify-write, or set delta
  always_comb begin
    if (state_r == ST_DELTA) begin
      add_a   = value_r;
      add_b   = acc_r;
      add_sub = 1'b1;
    end else if (wr_pend_r) begin
      add_a   = rd_q;
      add_b   = acc_r;
      add_sub = 1'b0;
    end else begin
      add_a   = acc_r;
      add_b   = rd_q;
      add_sub = rd_sub_r;
    end
    add_y = add_a + (add_sub ? ~add_b : add_b) + VW'(add_sub);
  end

  assign res_vw = (((op_r == OP_GET) || (op_r == OP_SUM)) && !err_r) ? acc_r : '0;

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    err_nxt        = err_r;
    clr_reply_nxt  = clr_reply_r;
    clr_addr_nxt   = clr_addr_r;
    r0_nxt         = r0_r;
    r1_nxt         = r1_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    walk_nxt       = walk_r;
    acc_nxt        = acc_r;
    value_nxt      = value_r;
    rd_pend_nxt    = 1'b0;
    rd_sub_nxt     = rd_sub_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;

    // fold in the read issued last cycle
    if (rd_pend_r) begin
      acc_nxt = add_y;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          value_nxt = VW'(in_value);
          acc_nxt   = '0;
          err_nxt   = 1'b0;
          walk_nxt  = '0;
          r0_nxt    = RIW'(in_row);
          c0_nxt    = CIW'(in_col);
          r1_nxt    = RIW'(in_row) + 1'b1;
          c1_nxt    = CIW'(in_col) + 1'b1;
          i_nxt     = RIW'(in_row) + 1'b1;
          j_nxt     = CIW'(in_col) + 1'b1;
          case (op_t'(in_operation))
            OP_ADD: begin
              if (cell_bad) begin
                err_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                acc_nxt   = VW'(in_value);
                state_nxt = ST_UPD;
              end
            end
            OP_SET, OP_GET: begin
              if (cell_bad) begin
                err_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            OP_SUM: begin
              r1_nxt = RIW'(in_row_end);
              c1_nxt = CIW'(in_col_end);
              i_nxt  = RIW'(in_row_end);
              j_nxt  = CIW'(in_col_end);
              if (rect_bad) begin
                err_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            OP_CLEAR: begin
              clr_reply_nxt = 1'b1;
              clr_addr_nxt  = '0;
              state_nxt     = ST_CLEAR;
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        // four prefix walks, signs + - - +
        if (i_r == '0) begin
          if (walk_r == WALK_LAST) begin
            state_nxt = ST_DRAIN;
          end else begin
            walk_nxt = walk_n;
            i_nxt    = rs_n;
            j_nxt    = cs_n;
          end
        end else if (j_r == '0) begin
          i_nxt = i_r & (i_r - 1'b1);
          j_nxt = cs;
        end else begin
          rd_pend_nxt = 1'b1;
          rd_sub_nxt  = walk_r[0] ^ walk_r[1];
          j_nxt       = j_r & (j_r - 1'b1);
        end
      end
      ST_DRAIN: begin
        state_nxt = (op_r == OP_SET) ? ST_DELTA : ST_DONE;
      end
      ST_DELTA: begin
        acc_nxt   = add_y;
        i_nxt     = r0_r + 1'b1;
        j_nxt     = c0_r + 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // read a node now, write it back next cycle
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = rd_addr;
        if (j_up > (CIW + 1)'(MAX_COLS)) begin
          if (i_up > (RIW + 1)'(MAX_ROWS)) begin
            state_nxt = ST_UPD_DRAIN;
          end else begin
            i_nxt = RIW'(i_up);
            j_nxt = c0_r + 1'b1;
          end
        end else begin
          j_nxt = CIW'(j_up);
        end
      end
      ST_UPD_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = DATA_W'(signed'(res_vw));
          out_error_nxt  = err_r;
          clr_reply_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_reply_r <= 1'b0;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_reply_r <= clr_reply_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    err_r        <= err_nxt;
    r0_r         <= r0_nxt;
    r1_r         <= r1_nxt;
    c0_r         <= c0_nxt;
    c1_r         <= c1_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    walk_r       <= walk_nxt;
    acc_r        <= acc_nxt;
    value_r      <= value_nxt;
    rd_sub_r     <= rd_sub_nxt;
    wr_addr_r    <= wr_addr_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ext_r <= EXT_RESET;
      col_ext_r <= EXT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_EXTENT: row_ext_r <= cfg_wdata;
        CFG_COL_EXTENT: col_ext_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Partial sum memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

// ----- src/gpars_checker.sv -----
module gpars_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [gpars_pkg::DATA_W-1:0] out_result,
  input logic                                out_error
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_error))
    else $error("stalled result changed");

  // Drop result to zero on error
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_result == '0)
    else $error("error result not zero");

  // Stay busy after reset while the grid is swept
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready right after reset");

  // Take one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind grid_point_add_rect_sum_top gpars_checker u_gpars_checker (.*);
